FILE: rtl/core/palindromic_tree_builder_assert.svh
// Assertion macros for the palindromic tree builder RTL; ptb_core uses them.
// Expects clk and rst_n in the scope of each use.
`ifndef PALINDROMIC_TREE_BUILDER_ASSERT_SVH
`define PALINDROMIC_TREE_BUILDER_ASSERT_SVH

// same-cycle implication
`define PTB_ASSERT_IMP(name, a, b) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ptb assertion failed");

// next-cycle implication
`define PTB_ASSERT_NXT(name, a, b) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ptb assertion failed");

`endif

FILE: rtl/core/ptb_pkg.sv
// Package for the palindromic tree builder: FSM states, root indexes, result type.
// No dependencies.
package ptb_pkg;

    localparam int FIELD_W   = 11;
    localparam int ROOT_EVEN = 0;
    localparam int ROOT_ODD  = 1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_TEXT,
        ST_NODE_RD,
        ST_POS,
        ST_CMP,
        ST_CHILD,
        ST_LINK_RD,
        ST_CHAIN,
        ST_NEW_WR,
        ST_PAR_WR,
        ST_HIT_RD,
        ST_HIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [FIELD_W-1:0] node_index;
        logic [FIELD_W-1:0] suffix_length;
        logic               created;
        logic [FIELD_W-1:0] suffix_count;
        logic               full_res;
    } res_t;

endpackage

FILE: rtl/core/ptb_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module ptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/core/ptb_core.sv
// Eertree sequencer: suffix-link walks, node creation, row read-modify-write.
// Depends on ptb_pkg and palindromic_tree_builder_assert.svh; drives the text and node-row RAMs.
module ptb_core #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [4:0]                                  in_symbol,
    input  logic                                        in_restart,
    output logic                                        res_valid,
    input  logic                                        res_ready,
    output ptb_pkg::res_t                               res,
    output logic                                        t_we,
    output logic [$clog2(MAX_LEN+1)-1:0]                t_addr,
    output logic [$clog2(ALPHABET)-1:0]                 t_wdata,
    input  logic [$clog2(ALPHABET)-1:0]                 t_rdata,
    output logic                                        n_we,
    output logic [$clog2(MAX_LEN+2)-1:0]                n_addr,
    output logic [(ALPHABET+1)*$clog2(MAX_LEN+2)+2*$clog2(MAX_LEN+1):0] n_wdata,
    input  logic [(ALPHABET+1)*$clog2(MAX_LEN+2)+2*$clog2(MAX_LEN+1):0] n_rdata
);
    import ptb_pkg::*;

    localparam int NODE_CAP = MAX_LEN + 2;
    localparam int IW    = $clog2(NODE_CAP);
    localparam int NW    = $clog2(MAX_LEN + 1);
    localparam int SW    = $clog2(ALPHABET);
    localparam int LW    = NW + 1;
    localparam int CW    = NW;
    localparam int PW    = NW + 2;
    localparam int CNTW  = $clog2(NODE_CAP + 1);
    localparam int CH_LO = IW + LW + CW;
    localparam int ROW_W = ALPHABET * IW + CH_LO;

    state_t state_reg, state_next;

    logic [NW-1:0]          text_len_reg;
    logic [IW-1:0]          last_reg;
    logic [CNTW-1:0]        cnt_reg;
    logic [SW-1:0]          sym_reg;
    logic [NW-1:0]          n_reg;
    logic [IW-1:0]          v_reg;
    logic [IW-1:0]          par_reg;
    logic                   walk2_reg;
    logic                   pend_reg;
    logic                   init_cnt_reg;
    logic [ROW_W-1:0]       cur_reg;
    logic signed [LW-1:0]   cur_len_reg;
    logic [IW-1:0]          cur_link_reg;
    logic [ROW_W-1:0]       vrow_reg;
    logic [LW-1:0]          newlen_reg;
    logic [IW-1:0]          link_nc_reg;
    logic [CW-1:0]          chain_reg;
    res_t                   res_reg;

    logic signed [LW-1:0]   rd_len;
    logic [IW-1:0]          rd_link;
    logic [CW-1:0]          rd_chain;
    logic signed [PW-1:0]   pos_s;
    logic                   pos_ok;
    logic                   match;
    logic [IW-1:0]          cur_child;
    logic                   full;
    logic                   room;
    logic [SW-1:0]          sym_sat;
    logic [ROW_W-1:0]       vrow_upd;
    logic [ROW_W-1:0]       new_row;

    always_comb
    begin
        if (v_reg == IW'(ROOT_EVEN))
        begin
            rd_len = '0;
        end
        else if (v_reg == IW'(ROOT_ODD))
        begin
            rd_len = '1;
        end
        else
        begin
            rd_len = n_rdata[IW +: LW];
        end
        rd_link  = (v_reg < IW'(2)) ? IW'(ROOT_ODD) : n_rdata[IW-1:0];
        rd_chain = (v_reg < IW'(2)) ? '0 : n_rdata[IW+LW +: CW];
    end

    assign pos_s     = $signed({2'b00, n_reg}) - PW'(rd_len) - PW'(1);
    assign pos_ok    = (pos_s > PW'(0));
    assign match     = (t_rdata == sym_reg);
    assign cur_child = cur_reg[CH_LO + sym_reg*IW +: IW];
    assign full      = (text_len_reg >= NW'(MAX_LEN));
    assign room      = (cnt_reg < CNTW'(NODE_CAP));
    assign sym_sat   = ({4'b0000, in_symbol} >= 9'(ALPHABET)) ? SW'(ALPHABET - 1)
                                                             : SW'(in_symbol);

    always_comb
    begin
        vrow_upd = vrow_reg;
        vrow_upd[CH_LO + sym_reg*IW +: IW] = IW'(cnt_reg);
    end

    assign new_row = {{(ALPHABET*IW){1'b0}}, chain_reg, newlen_reg, link_nc_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (init_cnt_reg)
                begin
                    state_next = pend_reg ? ST_TEXT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_restart)
                    begin
                        state_next = ST_INIT;
                    end
                    else if (full)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_TEXT;
                    end
                end
            end
            ST_TEXT:    state_next = ST_NODE_RD;
            ST_NODE_RD: state_next = ST_POS;
            ST_POS:     state_next = pos_ok ? ST_CMP : ST_NODE_RD;
            ST_CMP:
            begin
                if (!match)
                begin
                    state_next = ST_NODE_RD;
                end
                else
                begin
                    state_next = walk2_reg ? ST_LINK_RD : ST_CHILD;
                end
            end
            ST_CHILD:   state_next = (cur_child != '0 || !room) ? ST_HIT_RD : ST_NODE_RD;
            ST_LINK_RD: state_next = ST_CHAIN;
            ST_CHAIN:   state_next = ST_NEW_WR;
            ST_NEW_WR:  state_next = ST_PAR_WR;
            ST_PAR_WR:  state_next = ST_OUT;
            ST_HIT_RD:  state_next = ST_HIT;
            ST_HIT:     state_next = ST_OUT;
            ST_OUT:     state_next = res_ready ? ST_IDLE : ST_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory controls and handshake
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        t_we      = 1'b0;
        t_addr    = n_reg;
        t_wdata   = sym_reg;
        n_we      = 1'b0;
        n_addr    = v_reg;
        n_wdata   = '0;
        case (state_reg)
            ST_INIT:
            begin
                n_we   = 1'b1;
                n_addr = IW'(init_cnt_reg);
            end
            ST_IDLE:    in_ready = 1'b1;
            ST_TEXT:
            begin
                t_we   = 1'b1;
                t_addr = text_len_reg + NW'(1);
            end
            ST_POS:     t_addr = pos_s[NW-1:0];
            ST_LINK_RD: n_addr = link_nc_reg;
            ST_CHAIN:   n_addr = link_nc_reg;
            ST_NEW_WR:
            begin
                n_we    = 1'b1;
                n_addr  = IW'(cnt_reg);
                n_wdata = new_row;
            end
            ST_PAR_WR:
            begin
                n_we    = 1'b1;
                n_addr  = par_reg;
                n_wdata = vrow_upd;
            end
            ST_OUT:     res_valid = 1'b1;
            default:    n_addr = v_reg;
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            text_len_reg <= '0;
            last_reg     <= IW'(ROOT_EVEN);
            cnt_reg      <= CNTW'(2);
            pend_reg     <= 1'b0;
            init_cnt_reg <= 1'b0;
            walk2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_INIT:
                begin
                    init_cnt_reg <= !init_cnt_reg;
                    if (init_cnt_reg)
                    begin
                        pend_reg <= 1'b0;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        sym_reg <= sym_sat;
                        res_reg <= '0;
                        if (in_restart)
                        begin
                            text_len_reg <= '0;
                            last_reg     <= IW'(ROOT_EVEN);
                            cnt_reg      <= CNTW'(2);
                            pend_reg     <= 1'b1;
                            init_cnt_reg <= 1'b0;
                        end
                        else if (full)
                        begin
                            res_reg.full_res <= 1'b1;
                        end
                    end
                end
                ST_TEXT:
                begin
                    text_len_reg <= text_len_reg + NW'(1);
                    n_reg        <= text_len_reg + NW'(1);
                    v_reg        <= last_reg;
                    walk2_reg    <= 1'b0;
                    res_reg      <= '0;
                end
                ST_POS:
                begin
                    cur_reg      <= n_rdata;
                    cur_len_reg  <= rd_len;
                    cur_link_reg <= rd_link;
                    if (!pos_ok)
                    begin
                        v_reg <= rd_link;
                    end
                end
                ST_CMP:
                begin
                    if (!match)
                    begin
                        v_reg <= cur_link_reg;
                    end
                    else if (walk2_reg)
                    begin
                        link_nc_reg <= cur_child;
                    end
                end
                ST_CHILD:
                begin
                    if (cur_child != '0 || !room)
                    begin
                        v_reg <= cur_child;
                    end
                    else
                    begin
                        vrow_reg   <= cur_reg;
                        par_reg    <= v_reg;
                        newlen_reg <= LW'(cur_len_reg + LW'(2));
                        walk2_reg  <= 1'b1;
                        v_reg      <= cur_link_reg;
                    end
                end
                ST_CHAIN:
                begin
                    chain_reg <= ((link_nc_reg < IW'(2)) ? CW'(0) : n_rdata[IW+LW +: CW])
                                 + CW'(1);
                end
                ST_PAR_WR:
                begin
                    res_reg.node_index    <= FIELD_W'(cnt_reg);
                    res_reg.suffix_length <= FIELD_W'(newlen_reg);
                    res_reg.created       <= 1'b1;
                    res_reg.suffix_count  <= FIELD_W'(chain_reg);
                    last_reg              <= IW'(cnt_reg);
                    cnt_reg               <= cnt_reg + CNTW'(1);
                end
                ST_HIT:
                begin
                    res_reg.node_index    <= FIELD_W'(v_reg);
                    res_reg.suffix_length <= FIELD_W'(unsigned'(rd_len));
                    res_reg.suffix_count  <= FIELD_W'(rd_chain);
                    last_reg              <= v_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

`include "palindromic_tree_builder_assert.svh"

    `PTB_ASSERT_IMP(a_full_no_create, state_reg == ST_OUT && res_reg.full_res, !res_reg.created)
    `PTB_ASSERT_IMP(a_cnt_floor, 1'b1, cnt_reg >= CNTW'(2))
    `PTB_ASSERT_NXT(a_restart_init, in_valid && in_ready && in_restart, state_reg == ST_INIT)
    `PTB_ASSERT_IMP(a_new_len, state_reg == ST_OUT && res_reg.created,
                    res_reg.suffix_length != '0)

endmodule

FILE: rtl/core/palindromic_tree_builder.sv
// Top level of the palindromic tree builder: RAMs, sequencer, output register.
// Depends on ptb_pkg, ptb_ram, ptb_core.
//
//  channel | dir | tdata                                          | tuser
//  s_      | in  | [4:0] symbol                                   | [0] restart
//  m_      | out | [10:0] node_index [21:11] suffix_length         | [0] created
//          |     | [32:22] suffix_count                           | [1] full_res
//
// Per suffix-link step: one node-RAM read, a position check, and a symbol compare
// when in range. A hit reads its node row; creation writes the new and parent rows.
// A restart beat first clears the root rows, as reset does; a full beat skips the walk.
// The output register takes a beat while the next input runs.
module palindromic_tree_builder #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // symbol
    input  logic [0:0]  s_tuser,   // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // node_index, suffix_length, suffix_count
    output logic [1:0]  m_tuser    // created, full_res
);
    import ptb_pkg::*;

    localparam int NODE_CAP = MAX_LEN + 2;
    localparam int IW    = $clog2(NODE_CAP);
    localparam int NW    = $clog2(MAX_LEN + 1);
    localparam int SW    = $clog2(ALPHABET);
    localparam int ROW_W = (ALPHABET + 1) * IW + 2 * NW + 1;

    logic             t_we;
    logic [NW-1:0]    t_addr;
    logic [SW-1:0]    t_wdata;
    logic [SW-1:0]    t_rdata;
    logic             n_we;
    logic [IW-1:0]    n_addr;
    logic [ROW_W-1:0] n_wdata;
    logic [ROW_W-1:0] n_rdata;
    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             m_valid_reg;
    res_t             m_res_reg;

    ptb_ram #(.WIDTH(SW), .DEPTH(MAX_LEN + 1)) u_text_ram (
        .clk   (clk),
        .we    (t_we),
        .addr  (t_addr),
        .wdata (t_wdata),
        .rdata (t_rdata)
    );

    ptb_ram #(.WIDTH(ROW_W), .DEPTH(NODE_CAP)) u_node_ram (
        .clk   (clk),
        .we    (n_we),
        .addr  (n_addr),
        .wdata (n_wdata),
        .rdata (n_rdata)
    );

    ptb_core #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_symbol  (s_tdata[4:0]),
        .in_restart (s_tuser[0]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .t_we       (t_we),
        .t_addr     (t_addr),
        .t_wdata    (t_wdata),
        .t_rdata    (t_rdata),
        .n_we       (n_we),
        .n_addr     (n_addr),
        .n_wdata    (n_wdata),
        .n_rdata    (n_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0000000, m_res_reg.suffix_count, m_res_reg.suffix_length,
                       m_res_reg.node_index};
    assign m_tuser  = {m_res_reg.full_res, m_res_reg.created};

endmodule

FILE: dv/ptb_checker.sv
// Checker for the palindromic tree builder: watches both stream channels, predicts results.
// Depends on ptb_pkg for the result type and root indexes; stands beside the block in tb.
module ptb_checker #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          errors,
    output int          pending
);
    import ptb_pkg::*;

    localparam int NODES = MAX_LEN + 2;

    logic [4:0]  txt [0:MAX_LEN];
    int          slink [0:NODES-1];
    int          plen [0:NODES-1];
    int          kid [0:ALPHABET-1][0:NODES-1];
    int          depth [0:NODES-1];
    int          tlen, tail, nnodes;
    res_t        want_q[$];

    function automatic bit grows(int v, int n);
        int p;
        p = n - plen[v] - 1;
        if (p <= 0 || p > n) return 0;
        return txt[p] == txt[n];
    endfunction

    function automatic int climb(int v, int n);
        while (!grows(v, n)) v = slink[v];
        return v;
    endfunction

    task automatic clear_tree();
        for (int i = 0; i < NODES; i++)
        begin
            slink[i] = 0; plen[i] = 0; depth[i] = 0;
            for (int a = 0; a < ALPHABET; a++) kid[a][i] = 0;
        end
        plen[ROOT_ODD] = -1;
        slink[ROOT_EVEN] = ROOT_ODD;
        slink[ROOT_ODD] = ROOT_ODD;
        tlen = 0; tail = 0; nnodes = 2;
    endtask

    task automatic add_symbol(int sym, bit rs);
        res_t r;
        int n, v, f, nc, node;
        r = '0;
        if (rs) clear_tree();
        if (sym >= ALPHABET) sym = ALPHABET - 1;
        if (tlen >= MAX_LEN)
        begin
            r.full_res = 1;
        end
        else
        begin
            tlen++;
            n = tlen;
            txt[n] = sym[4:0];
            v = climb(tail, n);
            if (kid[sym][v] == 0 && nnodes < NODES)
            begin
                nc = nnodes;
                plen[nc] = plen[v] + 2;
                f = climb(slink[v], n);
                slink[nc] = kid[sym][f];
                depth[nc] = (depth[slink[nc] % NODES] + 1) & 'h7ff;
                kid[sym][v] = nc;
                nnodes = nc + 1;
                r.created = 1;
            end
            node = kid[sym][v] % NODES;
            tail = node;
            r.node_index = node[10:0];
            r.suffix_length = plen[node][10:0];
            r.suffix_count = depth[node][10:0];
        end
        want_q.push_back(r);
    endtask

    task automatic report(string what, int got, int exp);
        $display("ERROR %0s: got %0d expected %0d", what, got, exp);
        errors++;
    endtask

    always @(posedge clk)
    begin
        res_t e;
        if (!rst_n)
        begin
            errors = 0;
            clear_tree();
            want_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready) add_symbol(int'(s_tdata[4:0]), s_tuser[0]);
            if (m_tvalid && m_tready)
            begin
                if (want_q.size() == 0)
                    report("unexpected beat", 0, 0);
                else
                begin
                    e = want_q.pop_front();
                    if (m_tdata[10:0] != e.node_index)
                        report("node_index", m_tdata[10:0], e.node_index);
                    if (m_tdata[21:11] != e.suffix_length)
                        report("suffix_length", m_tdata[21:11], e.suffix_length);
                    if (m_tdata[32:22] != e.suffix_count)
                        report("suffix_count", m_tdata[32:22], e.suffix_count);
                    if (m_tuser[0] != e.created)
                        report("created", m_tuser[0], e.created);
                    if (m_tuser[1] != e.full_res)
                        report("full_res", m_tuser[1], e.full_res);
                end
            end
        end
        pending = want_q.size();
    end
endmodule

FILE: dv/tb.sv
// Testbench top for palindromic_tree_builder: clock, reset, stimulus and verdict.
// Depends on ptb_pkg, the block's RTL and ptb_checker.
module tb;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    int          send_idle;
    int          recv_stall;
    int          phase;

    localparam int WATCHDOG = 100000;

    palindromic_tree_builder u_top (.*);

    ptb_checker u_chk (.*);

    initial clk = 0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send(int sym, bit rs);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= 8'(sym);
        s_tuser  <= rs;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    initial
    begin
        int k, alpha, runlen;
        rst_n = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        send_idle = 0; recv_stall = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // directed: extremes, palindromes, saturation, restart
        send(0, 0); send(0, 0); send(25, 0); send(0, 0); send(0, 0);
        send(31, 0); send(26, 0); send(25, 0); send(8'hff, 0); send(0, 1);
        send(1, 0); send(0, 0); send(2, 0); send(0, 0); send(1, 0);
        send(0, 0); send(31, 1); send(31, 0); send(16, 0); send(15, 0);
        drain();
        // fill past capacity in one run
        send(3, 1);
        for (int i = 0; i < 1030; i++) send($urandom_range(1), 0);
        drain();
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle  = (phase == 1 || phase == 3) ? ((phase == 3) ? 15 : 78) : 0;
            recv_stall = (phase == 2 || phase == 3) ? ((phase == 3) ? 15 : 78) : 0;
            k = 0;
            while (k < 250)
            begin
                alpha = $urandom_range(3) == 0 ? 26 : $urandom_range(1, 4);
                runlen = $urandom_range(5, 60);
                for (int j = 0; j < runlen; j++)
                begin
                    if ($urandom_range(9) == 0)
                        send($urandom_range(255), 0);
                    else
                        send($urandom_range(alpha - 1), j == 0);
                    k++;
                end
            end
            drain();
        end
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
